// File: sv/rounded_rect_fan_vertex_gen_defines.svh
// Assertion macros for the vertex generator; only rrfvg_ctrl uses them.
// Each use expects clk and rst_n in scope.
`ifndef ROUNDED_RECT_FAN_VERTEX_GEN_DEFINES_SVH
`define ROUNDED_RECT_FAN_VERTEX_GEN_DEFINES_SVH

`ifndef SYNTH
`define RRFVG_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rrfvg assertion failed");
`define RRFVG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrfvg assertion failed");
`else
`define RRFVG_ASSERT(name, prop)
`define RRFVG_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: sv/rrfvg_pkg.sv
package rrfvg_pkg;

  localparam int MAX_SMOOTH = 13;
  localparam int SMOOTH_W   = 4;
  localparam int DIM_W      = 23;
  localparam int COORD_W    = 24;
  localparam int COLOR_W    = 32;
  localparam int SIN_W      = 16;
  localparam int PROD_W     = DIM_W + SIN_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [SMOOTH_W-1:0] MAX_SMOOTH_V = SMOOTH_W'(MAX_SMOOTH);
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'hFFFF_FFFF;
  localparam logic [PROD_W-1:0]   Q15_HALF     = PROD_W'(1 << 14);

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_SMOOTH = 3'd3,
    REG_COLOR  = 3'd4
  } reg_idx_t;

  // Sequencer states; each running state names the kind of vertex issued.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_EDGE,
    ST_ARC,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    radius;
    logic [SMOOTH_W-1:0] smooth;
    logic [COLOR_W-1:0]  color;
  } cfg_t;

  typedef struct packed {
    logic                issue;
    logic                load_center;
    state_t              kind;
    logic [1:0]          corner;
    logic [SMOOTH_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic                adv;
    logic [SMOOTH_W-1:0] n;
  } status_t;

  // Sine table indexed [n][k]: sin(k*90/n degrees) in Q1.15.
  typedef logic [MAX_SMOOTH+1:0][MAX_SMOOTH+1:0][SIN_W-1:0] sin_tab_t;

  function automatic logic [63:0] div_small(logic [63:0] num, int unsigned d);
    logic [63:0] q;
    case (d)
      1:       q = num / 1;
      2:       q = num / 2;
      3:       q = num / 3;
      4:       q = num / 4;
      5:       q = num / 5;
      6:       q = num / 6;
      7:       q = num / 7;
      8:       q = num / 8;
      9:       q = num / 9;
      10:      q = num / 10;
      11:      q = num / 11;
      12:      q = num / 12;
      13:      q = num / 13;
      14:      q = num / 14;
      default: q = num;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] taylor_div(logic [63:0] num, int unsigned i);
    logic [63:0] q;
    case (i)
      1:       q = num / 6;
      2:       q = num / 20;
      3:       q = num / 42;
      4:       q = num / 72;
      5:       q = num / 110;
      6:       q = num / 156;
      default: q = num;
    endcase
    return q;
  endfunction

  // Odd Taylor series through x^13 on a Q2.30 angle, rounded to Q1.15.
  function automatic logic [SIN_W-1:0] sine_q15(int unsigned k, int unsigned n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [SIN_W-1:0] res;
    if (n == 0 || k == 0) begin
      res = '0;
    end else if (k >= n) begin
      res = SIN_W'(32768);
    end else begin
      x = div_small(64'(k) * 64'd1686629713 + 64'(n >> 1), n);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = x;
      for (int unsigned i = 1; i <= 6; i++) begin
        term = taylor_div((term * x2) >> 30, i);
        if (i[0]) sum = sum - term;
        else sum = sum + term;
      end
      sum = (sum + (64'd1 << 14)) >> 15;
      if (sum > 64'd32768) sum = 64'd32768;
      res = sum[SIN_W-1:0];
    end
    return res;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int unsigned n = 0; n <= MAX_SMOOTH + 1; n++) begin
      for (int unsigned k = 0; k <= MAX_SMOOTH + 1; k++) begin
        t[n][k] = sine_q15(k, n);
      end
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// File: sv/rrfvg_regs.sv
module rrfvg_regs
  import rrfvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_nxt.width  = pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.height = pwdata[DIM_W-1:0];
        REG_RADIUS: cfg_nxt.radius = pwdata[DIM_W-1:0];
        REG_SMOOTH: cfg_nxt.smooth = pwdata[SMOOTH_W-1:0];
        REG_COLOR:  cfg_nxt.color  = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = DATA_W'(cfg_r.width);
      REG_HEIGHT: prdata = DATA_W'(cfg_r.height);
      REG_RADIUS: prdata = DATA_W'(cfg_r.radius);
      REG_SMOOTH: prdata = DATA_W'(cfg_r.smooth);
      REG_COLOR:  prdata = cfg_r.color;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= '0;
      cfg_r.height <= '0;
      cfg_r.radius <= '0;
      cfg_r.smooth <= '0;
      cfg_r.color  <= COLOR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/rrfvg_ctrl.sv
`include "rounded_rect_fan_vertex_gen_defines.svh"

module rrfvg_ctrl
  import rrfvg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t              state_r, state_nxt;
  logic [1:0]          corner_r, corner_nxt;
  logic [SMOOTH_W-1:0] k_r, k_nxt;
  logic                arc_done;

  assign arc_done = (k_r == sts.n);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CENTER;
      ST_CENTER: if (sts.adv) state_nxt = ST_EDGE;
      ST_EDGE:   if (sts.adv) state_nxt = ST_ARC;
      ST_ARC: begin
        if (sts.adv && arc_done) state_nxt = (corner_r == 2'd3) ? ST_CLOSE : ST_EDGE;
      end
      ST_CLOSE:  if (sts.adv) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Corner and arc step counters. The step stays at n once an arc is done, so
  // the sine table is never indexed past its last entry.
  always_comb begin
    corner_nxt = corner_r;
    k_nxt      = k_r;
    if (state_r == ST_IDLE) begin
      corner_nxt = 2'd0;
      k_nxt      = '0;
    end else if (sts.adv && state_r == ST_EDGE) begin
      k_nxt = SMOOTH_W'(1);
    end else if (sts.adv && state_r == ST_ARC) begin
      if (arc_done) corner_nxt = corner_r + 2'd1;
      else k_nxt = k_r + SMOOTH_W'(1);
    end
  end

  // Outputs.
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    cmd.issue       = (state_r != ST_IDLE);
    cmd.load_center = (state_r == ST_IDLE) && in_valid;
    cmd.kind        = state_r;
    cmd.corner      = corner_r;
    cmd.k           = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= 2'd0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      k_r      <= k_nxt;
    end
  end

  `RRFVG_ASSERT_NEXT(accept_starts_run, in_valid && !in_stall, state_r == ST_CENTER)
  `RRFVG_ASSERT_NEXT(close_ends_run, state_r == ST_CLOSE && sts.adv, state_r == ST_IDLE)
  `RRFVG_ASSERT(arc_step_in_range,
                (state_r == ST_ARC) |-> (k_r != '0 && k_r <= sts.n))

endmodule

// File: sv/rrfvg_datapath.sv
module rrfvg_datapath
  import rrfvg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output status_t                   sts,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_vertex_x,
  output logic signed [COORD_W-1:0] out_vertex_y,
  output logic [COLOR_W-1:0]        out_vertex_color,
  output logic                      out_last_vertex
);

  logic [SMOOTH_W-1:0] s_sat;
  logic [SMOOTH_W-1:0] n;
  logic [SMOOTH_W-1:0] cos_k;
  logic [SIN_W-1:0]    sin_v, cos_v;
  logic [COORD_W-1:0]  hx, hy, r;
  logic [COORD_W:0]    w_inc, h_inc;
  logic [COORD_W-1:0]  off_x, off_y;
  logic                adv;

  logic [COORD_W-1:0]  cx_r, cy_r;

  // Product stage.
  logic                a_valid_r;
  logic [COORD_W-1:0]  a_base_x_r, a_base_y_r;
  logic [PROD_W-1:0]   a_prod_s_r, a_prod_c_r;
  logic                a_arc_r, a_last_r;
  logic [1:0]          a_corner_r;

  // Output stage.
  logic                out_valid_r;
  logic [COORD_W-1:0]  out_x_r, out_y_r;
  logic                out_last_r;

  logic [PROD_W-1:0]   rs_sum, rc_sum;
  logic [COORD_W-1:0]  rs, rc, dx, dy;

  assign s_sat = (cfg.smooth > MAX_SMOOTH_V) ? MAX_SMOOTH_V : cfg.smooth;
  assign n     = s_sat + SMOOTH_W'(1);
  assign cos_k = n - cmd.k;
  assign sin_v = SIN_TAB[n][cmd.k];
  assign cos_v = SIN_TAB[n][cos_k];

  // Half sizes round to nearest, ties upward.
  assign w_inc = {2'b00, cfg.width} + (COORD_W + 1)'(1);
  assign h_inc = {2'b00, cfg.height} + (COORD_W + 1)'(1);
  assign hx    = w_inc[COORD_W:1];
  assign hy    = h_inc[COORD_W:1];
  assign r     = {1'b0, cfg.radius};

  assign adv     = !out_valid_r || !out_stall;
  assign sts.adv = adv;
  assign sts.n   = n;

  // Offset of the issued vertex from the request center (edge point or arc center).
  always_comb begin
    off_x = '0;
    off_y = '0;
    unique case (cmd.kind)
      ST_EDGE: begin
        case (cmd.corner)
          2'd0:    begin off_x = -hx;     off_y = r - hy; end
          2'd1:    begin off_x = hx - r;  off_y = -hy;    end
          2'd2:    begin off_x = hx;      off_y = hy - r; end
          default: begin off_x = r - hx;  off_y = hy;     end
        endcase
      end
      ST_ARC: begin
        case (cmd.corner)
          2'd0:    begin off_x = r - hx;  off_y = r - hy; end
          2'd1:    begin off_x = hx - r;  off_y = r - hy; end
          2'd2:    begin off_x = hx - r;  off_y = hy - r; end
          default: begin off_x = r - hx;  off_y = hy - r; end
        endcase
      end
      ST_CLOSE: begin
        off_x = -hx;
        off_y = r - hy;
      end
      default: begin
        off_x = '0;
        off_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_center) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= cmd.issue;
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_base_x_r <= cx_r + off_x;
      a_base_y_r <= cy_r + off_y;
      a_prod_s_r <= PROD_W'(cfg.radius) * PROD_W'(sin_v);
      a_prod_c_r <= PROD_W'(cfg.radius) * PROD_W'(cos_v);
      a_arc_r    <= (cmd.kind == ST_ARC);
      a_last_r   <= (cmd.kind == ST_CLOSE);
      a_corner_r <= cmd.corner;
    end
  end

  // Round the Q1.15 products back to Q15.8 and rotate them into the corner.
  assign rs_sum = a_prod_s_r + Q15_HALF;
  assign rc_sum = a_prod_c_r + Q15_HALF;
  assign rs     = rs_sum[PROD_W-1:15];
  assign rc     = rc_sum[PROD_W-1:15];

  always_comb begin
    dx = '0;
    dy = '0;
    if (a_arc_r) begin
      case (a_corner_r)
        2'd0:    begin dx = -rc; dy = -rs; end
        2'd1:    begin dx = rs;  dy = -rc; end
        2'd2:    begin dx = rc;  dy = rs;  end
        default: begin dx = -rs; dy = rc;  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r    <= a_base_x_r + dx;
      out_y_r    <= a_base_y_r + dy;
      out_last_r <= a_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_x     = $signed(out_x_r);
  assign out_vertex_y     = $signed(out_y_r);
  assign out_vertex_color = cfg.color;
  assign out_last_vertex  = out_last_r;

endmodule

// File: sv/rounded_rect_fan_vertex_gen.sv
// Rounded-rectangle triangle-fan vertex generator.
// The input channel (in_valid, in_stall, in_center_x, in_center_y) takes one
// item per rectangle: its center in signed Q15.8. For each item the result
// channel (out_valid, out_stall, out_vertex_*) delivers 10 + 4*S vertex items,
// S being the arc smoothness, capped at 13: the center, then per corner an edge point and
// S+1 arc points, clockwise from the top left, then the first edge point again
// with out_last_vertex set. Every vertex carries the configured fill color.
// The first vertex passes through the product and output registers after the
// item is accepted; then one vertex follows per cycle while the receiver does
// not stall. A new item is accepted in the cycle after the sequencer has issued
// the closing vertex, never earlier. While out_stall is high and a vertex waits
// at the output, the whole pipeline holds and the sequencer waits, so nothing is
// lost. The user must write size, radius, smoothness and color through the
// APB-style port only while the block is idle; the block does not enforce this.
// Reset empties the pipeline, returns the sequencer to idle and loads the
// register reset values (zero sizes, zero radius, zero smoothness, white color).
module rounded_rect_fan_vertex_gen
  import rrfvg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // Request channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  // Vertex channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_vertex_x,
  output logic signed [COORD_W-1:0] out_vertex_y,
  output logic [COLOR_W-1:0]        out_vertex_color,
  output logic                      out_last_vertex
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  // Register file; the user must ensure values stay fixed while a rectangle is being emitted (unenforced).
  rrfvg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: walks center, edge, arc and closing vertices one per cycle while the pipeline does not stall.
  rrfvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: sine lookup, radius products and center offsets in one stage,
  // rounding, corner rotation and the final sum into the output register in the next.
  rrfvg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_color (out_vertex_color),
    .out_last_vertex  (out_last_vertex)
  );

endmodule

// File: tb/rounded_rect_fan_vertex_gen_tb.sv
`timescale 1ns / 1ps

// Testbench for the rounded-rectangle fan vertex generator.
// Every accepted center item is expanded here into the full list of fan
// vertices that the block should emit. The list is built from the register
// values last written through the configuration port. A checker pops one
// vertex per accepted result and compares every field.
module rounded_rect_fan_vertex_gen_tb
  import rrfvg_pkg::*;
();

  // Consecutive cycles without any accepted transfer before the run is
  // declared hung. This leaves ample margin over the deliberate long hold,
  // the longest random gaps and a 62-vertex fan drained under heavy stalls.
  localparam int QUIET_LIMIT = 3000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int LONG_HOLD   = 300;
  // Idle cycles after the last vertex before a register write. This covers the
  // sequencer's return to idle after the closing vertex.
  localparam int SETTLE      = 4;
  // Idle cycles after the final vertex before the verdict.
  localparam int TAIL        = 20;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 30;

  // Addresses past the last register. Writes there must change nothing.
  localparam logic [ADDR_W-1:0] SPARE_ADDRS [3] = '{5'd20, 5'd24, 5'd28};

  localparam logic [COORD_W-1:0] COORD_MAX = 24'h7F_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 24'h80_0000;
  localparam logic [DIM_W-1:0]   DIM_MAX   = 23'h7F_FFFF;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic               in_valid;
  logic               in_stall;
  logic [COORD_W-1:0] in_center_x;
  logic [COORD_W-1:0] in_center_y;

  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] out_vertex_x;
  logic [COORD_W-1:0] out_vertex_y;
  logic [COLOR_W-1:0] out_vertex_color;
  logic               out_last_vertex;

  // This testbench's own copy of the configuration registers.
  logic [DIM_W-1:0]    fan_width;
  logic [DIM_W-1:0]    fan_height;
  logic [DIM_W-1:0]    fan_radius;
  logic [SMOOTH_W-1:0] fan_smooth;
  logic [COLOR_W-1:0]  fan_color;

  // Vertices predicted but not yet seen on the result channel, oldest first.
  vertex_t expected_vertices[$];

  int err_count     = 0;
  int quiet_cycles  = 0;
  bit idle_on       = 1'b1;
  int stall_left    = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  rounded_rect_fan_vertex_gen dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_color (out_vertex_color),
    .out_last_vertex  (out_last_vertex)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // sin(k*90/n degrees) in Q1.15. The angle goes to Q2.30 and is fed through
  // the odd Taylor series up to x^13. Each step rounds or truncates exactly as
  // the hardware table does, and the sum is rounded to Q1.15 at the end.
  function automatic logic [SIN_W-1:0] arc_sine(int unsigned k, int unsigned n);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    if (n == 0 || k == 0) return '0;
    if (k >= n) return SIN_W'(32768);
    ang    = (64'(k) * 64'd1686629713 + 64'(n / 2)) / 64'(n);
    ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
    term   = ang;
    acc    = ang;
    for (int i = 1; i <= 6; i++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    acc = (acc + (64'd1 << 14)) >> 15;
    if (acc > 64'd32768) acc = 64'd32768;
    return acc[SIN_W-1:0];
  endfunction

  // Radius times a Q1.15 factor, rounded to nearest with ties upward.
  function automatic logic [COORD_W-1:0] radius_scale(logic [COORD_W-1:0] r,
                                                      logic [SIN_W-1:0] f);
    return COORD_W'((64'(r) * 64'(f) + 64'd16384) >> 15);
  endfunction

  function automatic void add_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic last);
    expected_vertices.push_back('{x: x, y: y, color: fan_color, last: last});
  endfunction

  // Expands one center into its whole fan. All coordinates are 24-bit vectors,
  // so every sum wraps the way the hardware does.
  function automatic void predict_fan(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    logic [COORD_W-1:0] hx, hy, r, rs, rc, dx, dy;
    logic [COORD_W-1:0] start_x[4];
    logic [COORD_W-1:0] start_y[4];
    logic [COORD_W-1:0] arc_cx[4];
    logic [COORD_W-1:0] arc_cy[4];
    logic [SMOOTH_W-1:0] s_eff;
    int unsigned n;
    // Smoothness values above the maximum are treated as the maximum.
    s_eff = (fan_smooth > MAX_SMOOTH_V) ? MAX_SMOOTH_V : fan_smooth;
    n  = s_eff + 1;
    hx = COORD_W'((25'(fan_width) + 25'd1) >> 1);
    hy = COORD_W'((25'(fan_height) + 25'd1) >> 1);
    r  = COORD_W'(fan_radius);
    // Edge start points and arc centers, clockwise from the top left. The
    // radius is not clamped against the half sizes.
    start_x[0] = -hx;    start_y[0] = r - hy;
    start_x[1] = hx - r; start_y[1] = -hy;
    start_x[2] = hx;     start_y[2] = hy - r;
    start_x[3] = r - hx; start_y[3] = hy;
    arc_cx[0]  = r - hx; arc_cy[0]  = r - hy;
    arc_cx[1]  = hx - r; arc_cy[1]  = r - hy;
    arc_cx[2]  = hx - r; arc_cy[2]  = hy - r;
    arc_cx[3]  = r - hx; arc_cy[3]  = hy - r;

    add_vertex(cx, cy, 1'b0);
    for (int c = 0; c < 4; c++) begin
      add_vertex(cx + start_x[c], cy + start_y[c], 1'b0);
      for (int unsigned k = 1; k <= n; k++) begin
        rs = radius_scale(r, arc_sine(k, n));
        rc = radius_scale(r, arc_sine(n - k, n));
        case (c)
          0: begin
            dx = -rc; dy = -rs;
          end
          1: begin
            dx = rs;  dy = -rc;
          end
          2: begin
            dx = rc;  dy = rs;
          end
          default: begin
            dx = -rs; dy = rc;
          end
        endcase
        add_vertex(cx + arc_cx[c] + dx, cy + arc_cy[c] + dy, 1'b0);
      end
    end
    // The fan closes on the first edge point again.
    add_vertex(cx + start_x[0], cy + start_y[0], 1'b1);
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: prediction on accepted centers, checking of accepted
  // vertices, and the hang watchdog. All of them sample at the rising edge.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_fan(in_center_x, in_center_y);
    end
  end

  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex x=%h y=%h", out_vertex_x, out_vertex_y);
        err_count++;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (out_vertex_x !== exp_v.x) begin
          $error("vertex_x: expected %h, actual %h", exp_v.x, out_vertex_x);
          err_count++;
        end
        if (out_vertex_y !== exp_v.y) begin
          $error("vertex_y: expected %h, actual %h", exp_v.y, out_vertex_y);
          err_count++;
        end
        if (out_vertex_color !== exp_v.color) begin
          $error("vertex_color: expected %h, actual %h", exp_v.color, out_vertex_color);
          err_count++;
        end
        if (out_last_vertex !== exp_v.last) begin
          $error("last_vertex: expected %b, actual %b", exp_v.last, out_last_vertex);
          err_count++;
        end
      end
    end
  end

  // Any accepted transfer on either channel, or a register access, counts
  // as progress.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
        && !(psel && penable)) begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge.
  // ---------------------------------------------------------------------

  // Idle length: mostly short, sometimes a longer pause.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver. A requested long hold takes priority. Otherwise, while idling
  // is on, the receiver stalls at random for runs of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      stall_left = LONG_HOLD - 1;
      out_stall  = 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // One register write: a setup cycle, then an access cycle that completes
  // on the first rising edge with pready high. Starts and ends on a falling edge.
  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx_t'(addr[ADDR_W-1:2]))
      REG_WIDTH:  fan_width  = data[DIM_W-1:0];
      REG_HEIGHT: fan_height = data[DIM_W-1:0];
      REG_RADIUS: fan_radius = data[DIM_W-1:0];
      REG_SMOOTH: fan_smooth = data[SMOOTH_W-1:0];
      REG_COLOR:  fan_color  = data[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_shape(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [DIM_W-1:0] r, logic [SMOOTH_W-1:0] s,
                           logic [COLOR_W-1:0] color);
    cfg_write(reg_addr(REG_WIDTH), DATA_W'(w));
    cfg_write(reg_addr(REG_HEIGHT), DATA_W'(h));
    cfg_write(reg_addr(REG_RADIUS), DATA_W'(r));
    cfg_write(reg_addr(REG_SMOOTH), DATA_W'(s));
    cfg_write(reg_addr(REG_COLOR), color);
  endtask

  // Offers one center item, at times after a random gap when idling is on.
  // Returns on the falling edge after acceptance with valid still high. The
  // next item can then follow without a bubble.
  task automatic send_center(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_center_x = cx;
    in_center_y = cy;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted vertex has arrived. The
  // block is then idle and may be reconfigured.
  task automatic drain();
    in_valid = 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Coordinates: small ones near the origin, full-range ones and the extremes.
  function automatic logic [COORD_W-1:0] pick_coord();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return COORD_W'($urandom_range(0, 4096)) - 24'd2048;
    if (pick < 90) return COORD_W'($urandom);
    case ($urandom_range(0, 3))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return DIM_W'($urandom_range(0, 4096));
    if (pick < 80) return DIM_W'($urandom_range(0, 65535));
    return DIM_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // With reset values every vertex collapses onto the center and is white.
  task automatic test_reset_values();
    fan_width  = '0;
    fan_height = '0;
    fan_radius = '0;
    fan_smooth = '0;
    fan_color  = COLOR_RESET;
    send_center('0, '0);
    send_center(COORD_MAX, COORD_MIN);
    drain();
  endtask

  // Largest sizes and radius at the extreme centers make the coordinates
  // overflow and wrap. A small odd width with a huge radius checks the
  // half-size rounding and the missing radius clamp.
  task automatic test_extremes();
    set_shape(DIM_MAX, DIM_MAX, DIM_MAX, MAX_SMOOTH_V, '0);
    send_center(COORD_MAX, COORD_MAX);
    send_center(COORD_MIN, COORD_MIN);
    drain();
    set_shape(23'd3, 23'd0, DIM_MAX, 4'd1, 32'hA5A5_A5A5);
    send_center('0, '0);
    send_center(24'h12_3456, -24'h09_FBF1);
    drain();
  endtask

  // Every smoothness setting, including the two above the maximum, which
  // must behave as the maximum.
  task automatic test_smoothness_sweep();
    set_shape(23'h00_6400, 23'h00_3200, 23'h00_0A00, '0, $urandom);
    for (int s = 0; s < (1 << SMOOTH_W); s++) begin
      cfg_write(reg_addr(REG_SMOOTH), DATA_W'(s));
      send_center(pick_coord(), pick_coord());
      drain();
    end
  endtask

  // Writes beyond the register list must leave the shape untouched.
  task automatic test_spare_registers();
    set_shape(23'h00_2000, 23'h00_1800, 23'h00_0400, 4'd2, 32'h1234_5678);
    foreach (SPARE_ADDRS[i]) cfg_write(SPARE_ADDRS[i], $urandom);
    send_center(pick_coord(), pick_coord());
    drain();
  endtask

  // The receiver holds off for a long stretch while centers keep coming
  // back to back. The block fills up and must stall its input without
  // losing or reordering anything.
  task automatic test_backpressure();
    set_shape(23'h00_1000, 23'h00_2000, 23'h00_0300, 4'd3, $urandom);
    idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 6; i++) send_center(pick_coord(), pick_coord());
    drain();
    idle_on = 1'b1;
  endtask

  // Phases of random centers, each under a fresh random shape. Some phases
  // run with no idling on either side.
  task automatic test_random_fans();
    logic [DIM_W-1:0] w, h, r;
    int pick;
    for (int p = 0; p < PHASES; p++) begin
      w    = pick_dim();
      h    = pick_dim();
      pick = $urandom_range(0, 99);
      // Mostly a radius that fits the rectangle, sometimes one that does not.
      if (pick < 50) r = DIM_W'($urandom_range(0, ((w < h) ? w : h) / 2));
      else if (pick < 80) r = DIM_W'($urandom_range(0, 65535));
      else r = DIM_W'($urandom);
      set_shape(w, h, r, SMOOTH_W'($urandom_range(0, 15)), $urandom);
      idle_on = (p % 3 != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_center(pick_coord(), pick_coord());
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    in_center_x = '0;
    in_center_y = '0;
    out_stall   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_extremes();
    test_smoothness_sweep();
    test_spare_registers();
    test_backpressure();
    test_random_fans();

    drain();
    repeat (TAIL) @(posedge clk);
    if (err_count == 0 && expected_vertices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_vertices.size() != 0) begin
        $error("%0d vertices never arrived", expected_vertices.size());
      end
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
